>>> hw/rtl/mtlm_pkg.sv
package mtlm_pkg;

  localparam int MaxNodes   = 1024;
  localparam int NodeW      = $clog2(MaxNodes);
  localparam int CntW       = $clog2(MaxNodes + 1);
  localparam int UidW       = 32;
  localparam int ArityW     = 5;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 11;
  localparam int ProdW      = NodeW + ArityW;
  localparam int RecipW     = 17;
  localparam int RecipShift = 16;
  localparam int ParProdW   = NodeW + RecipW;
  localparam int DeltaW     = CntW + 2;

  typedef enum logic [1:0] {
    ACT_LOCK    = 2'd0,
    ACT_UNLOCK  = 2'd1,
    ACT_UPGRADE = 2'd2
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ARITY      = 2'd0,
    CFG_NODE_COUNT = 2'd1
  } cfg_index_e;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_X,
    CUR_ZERO,
    CUR_INC,
    CUR_PARENT,
    CUR_LO
  } cur_op_e;

  typedef enum logic [1:0] {
    LVL_HOLD,
    LVL_X,
    LVL_NEXT
  } lvl_op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_L_RD,
    ST_L_CHK,
    ST_U_RD,
    ST_U_CHK,
    ST_G_RD,
    ST_G_CHK,
    ST_S_LEVEL,
    ST_S_RD,
    ST_S_EVAL,
    ST_P_RD,
    ST_P_UPD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic    load_req;
    cur_op_e cur_op;
    lvl_op_e lvl_op;
    logic    wr_clear;
    logic    wr_path;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       in_range;
    logic       cur_is_x;
    logic       cur_is_zero;
    logic       cur_is_hi;
    logic       cur_is_last;
    logic       rd_locked;
    logic       rd_cnt_zero;
    logic       owner_match;
    logic       lvl_valid;
  } sts_t;

  // ceil(2^16 / m), exact parent for every node index below MaxNodes
  localparam logic [RecipW-1:0] Recip [32] = '{
    17'd65536, 17'd65536, 17'd32768, 17'd21846, 17'd16384, 17'd13108, 17'd10923, 17'd9363,
    17'd8192,  17'd7282,  17'd6554,  17'd5958,  17'd5462,  17'd5042,  17'd4682,  17'd4370,
    17'd4096,  17'd3856,  17'd3641,  17'd3450,  17'd3277,  17'd3121,  17'd2979,  17'd2850,
    17'd2731,  17'd2622,  17'd2521,  17'd2428,  17'd2341,  17'd2260,  17'd2185,  17'd2115
  };

endpackage

>>> hw/rtl/mtlm_datapath.sv
module mtlm_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mtlm_pkg::cmd_t                 cmd_i,
  input  logic [1:0]                     action_i,
  input  logic [mtlm_pkg::NodeW-1:0]     node_index_i,
  input  logic signed [mtlm_pkg::UidW-1:0] user_id_i,
  input  logic                           cfg_we_i,
  input  logic [mtlm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mtlm_pkg::CfgDataW-1:0]  cfg_data_i,
  output mtlm_pkg::sts_t                 sts_o
);
  import mtlm_pkg::*;

  logic [ArityW-1:0]   arity_q;
  logic [CntW-1:0]     node_count_q;
  logic [1:0]          act_q;
  logic [NodeW-1:0]    x_q, cur_q, cur_d, lo_q, hi_q;
  logic [UidW-1:0]     uid_q;
  logic signed [DeltaW-1:0] delta_q, delta_eff;

  logic [CntW:0]       stat_mem [MaxNodes];
  logic [UidW-1:0]     own_mem [MaxNodes];
  logic [CntW:0]       stat_rd_q, stat_wdata;
  logic [UidW-1:0]     own_rd_q;
  logic                stat_we, own_we;

  logic [ArityW-1:0]   eff_m;
  logic [CntW-1:0]     eff_n;
  logic [ParProdW-1:0] par_prod;
  logic [NodeW-1:0]    parent;
  logic [ProdW-1:0]    lo_n, hi_n, hi_clip;
  logic                rd_locked, new_locked;
  logic [CntW-1:0]     rd_cnt, new_cnt;
  logic signed [DeltaW-1:0] cnt_sum;

  assign eff_m = (arity_q == '0) ? ArityW'(1) : arity_q;
  assign eff_n = (node_count_q > CntW'(MaxNodes)) ? CntW'(MaxNodes) : node_count_q;

  assign par_prod = ParProdW'(cur_q - NodeW'(1)) * ParProdW'(Recip[eff_m]);
  assign parent   = par_prod[RecipShift +: NodeW];

  assign lo_n    = ProdW'(lo_q) * ProdW'(eff_m) + ProdW'(1);
  assign hi_n    = ProdW'(hi_q) * ProdW'(eff_m) + ProdW'(eff_m);
  assign hi_clip = (hi_n >= ProdW'(eff_n)) ? ProdW'(eff_n - CntW'(1)) : hi_n;

  assign rd_locked = stat_rd_q[CntW];
  assign rd_cnt    = stat_rd_q[CntW-1:0];

  always_comb begin
    unique case (act_q)
      ACT_LOCK:   delta_eff = DeltaW'(1);
      ACT_UNLOCK: delta_eff = -DeltaW'(1);
      default:    delta_eff = (cur_q == x_q) ? DeltaW'(1) - DeltaW'(rd_cnt) : delta_q;
    endcase
    cnt_sum    = DeltaW'(rd_cnt) + delta_eff;
    new_cnt    = cnt_sum[DeltaW-1] ? '0 : cnt_sum[CntW-1:0];
    new_locked = (cur_q == x_q) ? (act_q != ACT_UNLOCK) : rd_locked;
    stat_we    = cmd_i.wr_clear | cmd_i.wr_path;
    stat_wdata = cmd_i.wr_clear ? '0 : {new_locked, new_cnt};
    own_we     = cmd_i.wr_path & (cur_q == x_q) & (act_q != ACT_UNLOCK);
  end

  always_comb begin
    unique case (cmd_i.cur_op)
      CUR_HOLD:   cur_d = cur_q;
      CUR_X:      cur_d = x_q;
      CUR_ZERO:   cur_d = '0;
      CUR_INC:    cur_d = cur_q + NodeW'(1);
      CUR_PARENT: cur_d = parent;
      CUR_LO:     cur_d = lo_n[NodeW-1:0];
      default:    cur_d = cur_q;
    endcase
    if (cmd_i.load_req) begin
      cur_d = node_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arity_q      <= ArityW'(2);
      node_count_q <= CntW'(MaxNodes);
      cur_q        <= '0;
    end else begin
      cur_q <= cur_d;
      if (cfg_we_i && cfg_index_i == CFG_ARITY) begin
        arity_q <= cfg_data_i[ArityW-1:0];
      end
      if (cfg_we_i && cfg_index_i == CFG_NODE_COUNT) begin
        node_count_q <= cfg_data_i[CntW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      act_q <= action_i;
      x_q   <= node_index_i;
      uid_q <= user_id_i;
    end
    unique case (cmd_i.lvl_op)
      LVL_X: begin
        lo_q <= x_q;
        hi_q <= x_q;
      end
      LVL_NEXT: begin
        lo_q <= lo_n[NodeW-1:0];
        hi_q <= hi_clip[NodeW-1:0];
      end
      default: begin
        lo_q <= lo_q;
        hi_q <= hi_q;
      end
    endcase
    if (cmd_i.wr_path && cur_q == x_q) begin
      delta_q <= delta_eff;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat_we) begin
      stat_mem[cur_q] <= stat_wdata;
    end
    stat_rd_q <= stat_mem[cur_q];
  end

  always_ff @(posedge clk_i) begin
    if (own_we) begin
      own_mem[cur_q] <= uid_q;
    end
    own_rd_q <= own_mem[cur_q];
  end

  assign sts_o.act         = act_q;
  assign sts_o.in_range    = CntW'(x_q) < eff_n;
  assign sts_o.cur_is_x    = cur_q == x_q;
  assign sts_o.cur_is_zero = cur_q == '0;
  assign sts_o.cur_is_hi   = cur_q == hi_q;
  assign sts_o.cur_is_last = cur_q == NodeW'(MaxNodes - 1);
  assign sts_o.rd_locked   = rd_locked;
  assign sts_o.rd_cnt_zero = rd_cnt == '0;
  assign sts_o.owner_match = own_rd_q == uid_q;
  assign sts_o.lvl_valid   = lo_n < ProdW'(eff_n);

endmodule

>>> hw/rtl/mtlm_ctrl.sv
module mtlm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output logic           granted_o,
  input  logic           cfg_clear_i,
  input  mtlm_pkg::sts_t sts_i,
  output mtlm_pkg::cmd_t cmd_o
);
  import mtlm_pkg::*;

  state_e state_q, state_d;
  logic   rel_q, rel_d;
  logic   grant_q, grant_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   rsp_granted_q, rsp_granted_d;

  assign req_ready_o = state_q == ST_IDLE;
  assign rsp_valid_o = rsp_valid_q;
  assign granted_o   = rsp_granted_q;

  always_comb begin
    state_d       = state_q;
    rel_d         = rel_q;
    grant_d       = grant_q;
    rsp_valid_d   = rsp_valid_q & ~rsp_ready_i;
    rsp_granted_d = rsp_granted_q;
    cmd_o         = '{load_req: 1'b0, cur_op: CUR_HOLD, lvl_op: LVL_HOLD,
                      wr_clear: 1'b0, wr_path: 1'b0};

    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.wr_clear = 1'b1;
        if (sts_i.cur_is_last) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.cur_op = CUR_INC;
        end
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = ST_START;
        end
      end
      ST_START: begin
        grant_d = 1'b0;
        if (!sts_i.in_range) begin
          state_d = ST_DONE;
        end else begin
          unique case (sts_i.act)
            ACT_LOCK:    state_d = ST_L_RD;
            ACT_UNLOCK:  state_d = ST_U_RD;
            ACT_UPGRADE: state_d = ST_G_RD;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_L_RD: state_d = ST_L_CHK;
      ST_L_CHK: begin
        if (sts_i.rd_locked || (sts_i.cur_is_x && !sts_i.rd_cnt_zero)) begin
          state_d = ST_DONE;
        end else if (sts_i.cur_is_zero) begin
          cmd_o.cur_op = CUR_X;
          state_d      = ST_P_RD;
        end else begin
          cmd_o.cur_op = CUR_PARENT;
          state_d      = ST_L_RD;
        end
      end
      ST_U_RD: state_d = ST_U_CHK;
      ST_U_CHK: begin
        state_d = (sts_i.rd_locked && sts_i.owner_match) ? ST_P_RD : ST_DONE;
      end
      ST_G_RD: state_d = ST_G_CHK;
      ST_G_CHK: begin
        if (sts_i.rd_locked) begin
          state_d = ST_DONE;
        end else begin
          rel_d        = 1'b0;
          cmd_o.lvl_op = LVL_X;
          state_d      = ST_S_LEVEL;
        end
      end
      ST_S_LEVEL: begin
        if (sts_i.lvl_valid) begin
          cmd_o.lvl_op = LVL_NEXT;
          cmd_o.cur_op = CUR_LO;
          state_d      = ST_S_RD;
        end else if (rel_q) begin
          cmd_o.cur_op = CUR_X;
          state_d      = ST_P_RD;
        end else begin
          rel_d        = 1'b1;
          cmd_o.lvl_op = LVL_X;
        end
      end
      ST_S_RD: state_d = ST_S_EVAL;
      ST_S_EVAL: begin
        cmd_o.wr_clear = rel_q;
        if (!rel_q && sts_i.rd_locked && !sts_i.owner_match) begin
          cmd_o.wr_clear = 1'b0;
          state_d        = ST_DONE;
        end else if (sts_i.cur_is_hi) begin
          state_d = ST_S_LEVEL;
        end else begin
          cmd_o.cur_op = CUR_INC;
          state_d      = ST_S_RD;
        end
      end
      ST_P_RD: state_d = ST_P_UPD;
      ST_P_UPD: begin
        cmd_o.wr_path = 1'b1;
        if (sts_i.cur_is_zero) begin
          grant_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          cmd_o.cur_op = CUR_PARENT;
          state_d      = ST_P_RD;
        end
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_valid_d   = 1'b1;
          rsp_granted_d = grant_q;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase

    if (cfg_clear_i) begin
      state_d        = ST_CLEAR;
      cmd_o.cur_op   = CUR_ZERO;
      cmd_o.load_req = 1'b0;
      cmd_o.wr_clear = 1'b0;
      cmd_o.wr_path  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      rel_q         <= 1'b0;
      grant_q       <= 1'b0;
      rsp_valid_q   <= 1'b0;
      rsp_granted_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      rel_q         <= rel_d;
      grant_q       <= grant_d;
      rsp_valid_q   <= rsp_valid_d;
      rsp_granted_q <= rsp_granted_d;
    end
  end

endmodule

>>> hw/rtl/m_ary_tree_lock_manager_core.sv
// Hierarchical lock manager over an implicit m-ary tree (parent of node i is (i-1)/arity),
// one request at a time, one granted/refused response per request unless a clearing
// configuration write aborts it. Node state lives in two single-port memories, so each
// visited node is read by address, then as registered data. A lock walks from the node
// to the root twice (check, then count update). An unlock checks the node, then walks
// the path to the root once. An upgrade scans the node's descendants twice (check
// owners, then release), then updates the path to the root. After reset and after every
// write to arity or node_count the state memory is swept, while no request is taken.
module m_ary_tree_lock_manager_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  output logic                            req_ready_o,
  input  logic [1:0]                      action_i,
  input  logic [mtlm_pkg::NodeW-1:0]      node_index_i,
  input  logic signed [mtlm_pkg::UidW-1:0] user_id_i,
  output logic                            rsp_valid_o,
  input  logic                            rsp_ready_i,
  output logic                            granted_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mtlm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [mtlm_pkg::CfgDataW-1:0]   cfg_data_i
);
  import mtlm_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_we, cfg_clear;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign cfg_clear   = cfg_we & ((cfg_index_i == CFG_ARITY) ||
                                 (cfg_index_i == CFG_NODE_COUNT));

  mtlm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .granted_o   (granted_o),
    .cfg_clear_i (cfg_clear),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mtlm_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .action_i     (action_i),
    .node_index_i (node_index_i),
    .user_id_i    (user_id_i),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .sts_o        (sts)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o && !cfg_clear) |=> !req_ready_o)
    else $error("request accepted while not busy afterwards");

  a_clear_after_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_clear |=> !req_ready_o)
    else $error("configuration write did not start the clear pass");

  a_rsp_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_o) |-> $past(!req_ready_o))
    else $error("response raised without a request in progress");
`endif

endmodule
